FILE: design/sru_pkg.sv
package sru_pkg;

   localparam int unsigned WordWidth = 16;
   localparam int unsigned ByteWidth = 8;
   localparam int unsigned CountWidth = 8;
   localparam int unsigned FunnelWidth = 2 * (WordWidth + 1);
   localparam int unsigned AmountWidth = 5;
   localparam int unsigned QuotWidth = 5;

   localparam logic [2:0] OP_ROL = 3'd0;
   localparam logic [2:0] OP_ROR = 3'd1;
   localparam logic [2:0] OP_RCL = 3'd2;
   localparam logic [2:0] OP_RCR = 3'd3;
   localparam logic [2:0] OP_SHL = 3'd4;
   localparam logic [2:0] OP_SHR = 3'd5;
   localparam logic [2:0] OP_SAR = 3'd6;

   // Reciprocals scaled by 256 for the through-carry ring lengths of 17 and 9 bits.
   localparam logic [4:0] RECIP_RING_WORD = 5'd15;
   localparam logic [4:0] RECIP_RING_BYTE = 5'd28;

   typedef struct packed {
      logic [2:0]  operation;
      logic [15:0] operand;
      logic        wide_word;
      logic [7:0]  shift_count;
      logic        carry_in;
   } req_type;

   typedef struct packed {
      logic [15:0] shifted;
      logic        last_out_bit;
      logic        last_bit_valid;
      logic        carry_out;
   } rsp_type;

   typedef struct packed {
      logic [2:0]           operation;
      logic [15:0]          value;
      logic                 wide;
      logic [7:0]           count;
      logic                 carry_in;
      logic                 active;
      logic [QuotWidth-1:0] quot_est;
   } decode_type;

   typedef struct packed {
      logic [2:0]             operation;
      logic [15:0]            value;
      logic                   wide;
      logic                   carry_in;
      logic                   active;
      logic [FunnelWidth-1:0] funnel;
      logic [AmountWidth-1:0] amount;
   } prepare_type;

   typedef struct packed {
      logic [2:0]  operation;
      logic [15:0] value;
      logic        wide;
      logic        carry_in;
      logic        active;
      logic [16:0] moved;
   } shift_type;

endpackage

FILE: design/x86_shift_rotate_unit.sv
// Shift and rotate unit for byte and word operands: ROL, ROR, RCL, RCR, SHL, SHR and SAR.
// A request on the req_ channel carries the operation, the operand, the width select, an
// 8-bit count and the carry flag. Each request yields exactly one response on the rsp_
// channel with the shifted value, the last bit moved out, its valid flag and the new carry.
// Both channels use valid and ready; a transfer happens at a clock edge where both are high.
// The unit is a four-stage pipeline: decode and reciprocal estimate, remainder and funnel
// setup, a 34-bit funnel shifter, and result formatting into the output register.
// A request passes through the decode, prepare, shift and format registers to rsp_valid, and one request is taken
// every cycle while rsp_ready stays high.
// When the receiver holds rsp_ready low, each stage keeps its request and stops taking new
// ones once it is full, so up to four requests wait in the pipeline and none is lost or
// repeated; req_ready falls once the pipeline is full.
// A synchronous reset empties all stages; the unit has no other state.
module x86_shift_rotate_unit
   import sru_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic        dec_valid;
   logic        dec_ready;
   decode_type  dec_data;
   logic        prep_valid;
   logic        prep_ready;
   prepare_type prep_data;
   logic        sh_valid;
   logic        sh_ready;
   shift_type   sh_data;

   sru_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (dec_valid),
      .out_ready (dec_ready),
      .out_data  (dec_data)
   );

   sru_prepare u_prepare (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_data   (dec_data),
      .out_valid (prep_valid),
      .out_ready (prep_ready),
      .out_data  (prep_data)
   );

   sru_shift u_shift (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_valid),
      .in_ready  (prep_ready),
      .in_data   (prep_data),
      .out_valid (sh_valid),
      .out_ready (sh_ready),
      .out_data  (sh_data)
   );

   sru_format u_format (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sh_valid),
      .in_ready  (sh_ready),
      .in_data   (sh_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   // A request accepted while rsp_ready stays high passes the decode, prepare, shift and format registers to rsp_valid.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && rsp_ready) ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready
      |=> rsp_valid)
      else $error("request did not reach the output in four cycles");

   // With a zero count or an unused code there is no bit moved out.
   a_last_bit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last_bit_valid) |-> !rsp_data.last_out_bit)
      else $error("last bit set without a nonzero count");

   // A byte-wide request that leaves the shifter yields no bits above the low byte.
   a_byte_mask: assert property (@(posedge clock) disable iff (reset)
      (sh_valid && sh_ready && !sh_data.wide) |=> (rsp_data.shifted[15:8] == 8'd0))
      else $error("byte result has bits above the low byte");

   // The pipeline is empty right after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_valid && !sh_valid && !prep_valid && !dec_valid))
      else $error("pipeline not empty after reset");

endmodule

FILE: design/sru_decode.sv
module sru_decode
   import sru_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  req_type    in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output decode_type out_data
);

   logic       valid_ff;
   logic       valid_in;
   decode_type data_ff;
   decode_type data_in;
   logic [12:0] product;
   logic [4:0]  recip;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      recip = in_data.wide_word ? RECIP_RING_WORD : RECIP_RING_BYTE;
      product = {5'b0, in_data.shift_count} * {8'b0, recip};
      data_in.operation = in_data.operation;
      data_in.value = in_data.wide_word ? in_data.operand : {8'b0, in_data.operand[7:0]};
      data_in.wide = in_data.wide_word;
      data_in.count = in_data.shift_count;
      data_in.carry_in = in_data.carry_in;
      data_in.active = (in_data.shift_count != 8'd0) && (in_data.operation <= OP_SAR);
      data_in.quot_est = product[12:8];
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

endmodule

FILE: design/sru_prepare.sv
module sru_prepare
   import sru_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  decode_type  in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output prepare_type out_data
);

   logic        valid_ff;
   logic        valid_in;
   prepare_type data_ff;
   prepare_type data_in;

   logic [4:0]  ring_len;
   logic [4:0]  word_len;
   logic [9:0]  quot_times_len;
   logic [9:0]  diff;
   logic [5:0]  rem_raw;
   logic [5:0]  rem;
   logic [4:0]  rot_k;
   logic [4:0]  clamp_k;
   logic        sign;
   logic [15:0] sext;
   logic [15:0] v;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      v = in_data.value;
      ring_len = in_data.wide ? 5'(WordWidth + 1) : 5'(ByteWidth + 1);
      word_len = in_data.wide ? 5'(WordWidth) : 5'(ByteWidth);
      quot_times_len = {5'b0, in_data.quot_est} * {5'b0, ring_len};
      diff = {2'b0, in_data.count} - quot_times_len;
      rem_raw = diff[5:0];
      rem = (rem_raw >= {1'b0, ring_len}) ? (rem_raw - {1'b0, ring_len}) : rem_raw;
      rot_k = in_data.wide ? {1'b0, in_data.count[3:0]} : {2'b0, in_data.count[2:0]};
      clamp_k = (in_data.count > {3'b0, word_len}) ? ring_len : in_data.count[4:0];
      sign = in_data.wide ? v[15] : v[7];
      sext = in_data.wide ? v : {{8{v[7]}}, v[7:0]};

      data_in.operation = in_data.operation;
      data_in.value = v;
      data_in.wide = in_data.wide;
      data_in.carry_in = in_data.carry_in;
      data_in.active = in_data.active;
      data_in.funnel = '0;
      data_in.amount = '0;

      case (in_data.operation)
         OP_ROL, OP_ROR: begin
            data_in.funnel = in_data.wide ? {2'b0, v, v} : {18'b0, v[7:0], v[7:0]};
            data_in.amount = (in_data.operation == OP_ROR) ? rot_k : (word_len - rot_k);
         end
         OP_RCL, OP_RCR: begin
            data_in.funnel = in_data.wide
               ? {in_data.carry_in, v, in_data.carry_in, v}
               : {16'b0, in_data.carry_in, v[7:0], in_data.carry_in, v[7:0]};
            data_in.amount = (in_data.operation == OP_RCR) ? rem[4:0] : (ring_len - rem[4:0]);
         end
         OP_SHL: begin
            data_in.funnel = {1'b0, v, 17'b0};
            data_in.amount = 5'(WordWidth + 1) - clamp_k;
         end
         OP_SHR: begin
            data_in.funnel = {17'b0, v, 1'b0};
            data_in.amount = clamp_k;
         end
         OP_SAR: begin
            data_in.funnel = {{17{sign}}, sext, 1'b0};
            data_in.amount = clamp_k;
         end
         default: begin
            data_in.funnel = '0;
            data_in.amount = '0;
         end
      endcase

      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

endmodule

FILE: design/sru_shift.sv
module sru_shift
   import sru_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  prepare_type in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output shift_type   out_data
);

   logic                   valid_ff;
   logic                   valid_in;
   shift_type              data_ff;
   shift_type              data_in;
   logic [FunnelWidth-1:0] funnel_out;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      funnel_out = in_data.funnel >> in_data.amount;
      data_in.operation = in_data.operation;
      data_in.value = in_data.value;
      data_in.wide = in_data.wide;
      data_in.carry_in = in_data.carry_in;
      data_in.active = in_data.active;
      data_in.moved = funnel_out[16:0];
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

endmodule

FILE: design/sru_format.sv
module sru_format
   import sru_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  shift_type in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output rsp_type   out_data
);

   logic        valid_ff;
   logic        valid_in;
   rsp_type     data_ff;
   rsp_type     data_in;
   logic [15:0] mask;
   logic [16:0] y;
   logic        width_bit;
   logic        top_bit;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      y = in_data.moved;
      mask = in_data.wide ? 16'hFFFF : 16'h00FF;
      width_bit = in_data.wide ? y[16] : y[8];
      top_bit = in_data.wide ? y[15] : y[7];

      data_in.shifted = y[15:0] & mask;
      data_in.last_out_bit = 1'b0;
      data_in.last_bit_valid = 1'b1;
      data_in.carry_out = in_data.carry_in;

      case (in_data.operation)
         OP_ROL: data_in.last_out_bit = y[0];
         OP_ROR: data_in.last_out_bit = top_bit;
         OP_RCL: begin
            data_in.last_out_bit = y[0];
            data_in.carry_out = width_bit;
         end
         OP_RCR: begin
            data_in.last_out_bit = width_bit;
            data_in.carry_out = width_bit;
         end
         OP_SHL: data_in.last_out_bit = width_bit;
         OP_SHR, OP_SAR: begin
            data_in.shifted = y[16:1] & mask;
            data_in.last_out_bit = y[0];
         end
         default: data_in.last_out_bit = 1'b0;
      endcase

      if (!in_data.active) begin
         data_in.shifted = in_data.value;
         data_in.last_out_bit = 1'b0;
         data_in.last_bit_valid = 1'b0;
         data_in.carry_out = in_data.carry_in;
      end

      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

endmodule

FILE: tb/tb_x86_shift_rotate_unit.sv
`timescale 1ns / 100ps

module tb_x86_shift_rotate_unit
   import sru_pkg::*;
;

   localparam int HOLD_OFF_CYCLES = 80;
   localparam int RANDOM_REQUESTS = 1250;
   localparam logic [2:0] OP_UNUSED = 3'd7;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type result;
   } stimulus_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   rsp_type          pending_results[$];
   stimulus_row_type directed_rows[$];
   int               requests_sent = 0;
   int               responses_checked = 0;
   int               mismatch_count = 0;
   int               hold_off_count = 0;
   bit               hold_off_request = 1'b0;

   x86_shift_rotate_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic rsp_type predict_shift(input req_type r);
      rsp_type     res;
      int unsigned w;
      int unsigned i;
      logic [31:0] mask;
      logic [31:0] ring_mask;
      logic [31:0] v;
      logic [31:0] ring;
      logic        sign;
      logic        b;
      logic        last;
      logic        cout;
      logic        valid;
      w = r.wide_word ? WordWidth : ByteWidth;
      mask = (32'd1 << w) - 32'd1;
      v = {16'b0, r.operand} & mask;
      sign = v[w - 1];
      last = 1'b0;
      cout = r.carry_in;
      valid = 1'b0;
      b = 1'b0;
      if (r.shift_count != 8'd0 && r.operation <= OP_SAR) begin
         valid = 1'b1;
         if (r.operation == OP_RCL || r.operation == OP_RCR) begin
            ring_mask = (32'd1 << (w + 1)) - 32'd1;
            ring = v | ({31'b0, r.carry_in} << w);
            for (i = 0; i < r.shift_count; i++) begin
               if (r.operation == OP_RCL) begin
                  b = ring[w];
                  ring = ((ring << 1) & ring_mask) | {31'b0, b};
               end else begin
                  b = ring[0];
                  ring = (ring >> 1) | ({31'b0, b} << w);
               end
               last = b;
            end
            cout = ring[w];
            v = ring & mask;
         end else begin
            for (i = 0; i < r.shift_count; i++) begin
               case (r.operation)
                  OP_ROL: begin
                     b = v[w - 1];
                     v = ((v << 1) & mask) | {31'b0, b};
                  end
                  OP_ROR: begin
                     b = v[0];
                     v = (v >> 1) | ({31'b0, b} << (w - 1));
                  end
                  OP_SHL: begin
                     b = v[w - 1];
                     v = (v << 1) & mask;
                  end
                  OP_SHR: begin
                     b = v[0];
                     v = v >> 1;
                  end
                  default: begin
                     b = v[0];
                     v = (v >> 1) | ({31'b0, sign} << (w - 1));
                  end
               endcase
               last = b;
            end
         end
      end
      res.shifted = v[15:0] & mask[15:0];
      res.last_out_bit = last;
      res.last_bit_valid = valid;
      res.carry_out = cout;
      return res;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic req_type random_request();
      req_type r;
      int      roll;
      roll = $urandom_range(0, 99);
      r.operation = (roll < 8) ? OP_UNUSED : 3'($urandom_range(0, 6));
      r.operand = 16'($urandom);
      r.wide_word = 1'($urandom_range(0, 1));
      r.carry_in = 1'($urandom_range(0, 1));
      roll = $urandom_range(0, 99);
      if (roll < 5) r.shift_count = 8'd0;
      else if (roll < 8) r.shift_count = 8'd255;
      else if (roll < 70) r.shift_count = 8'($urandom_range(1, 20));
      else r.shift_count = 8'($urandom_range(0, 255));
      return r;
   endfunction

   function automatic void add_row(input req_type q, input bit typed, input rsp_type e);
      stimulus_row_type row;
      row.req = q;
      row.typed = typed;
      row.result = e;
      directed_rows.push_back(row);
   endfunction

   task automatic send_request(input req_type item, input rsp_type result);
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.push_back(result);
      requests_sent++;
   endtask

   task automatic idle_sender(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   initial begin
      int      burst_left;
      req_type item;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      burst_left = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      add_row(req_type'{OP_ROL, 16'hFFA5, 1'b0, 8'd0, 1'b1}, 1'b1,
              rsp_type'{16'h00A5, 1'b0, 1'b0, 1'b1});
      add_row(req_type'{OP_UNUSED, 16'hFFFF, 1'b1, 8'd5, 1'b0}, 1'b1,
              rsp_type'{16'hFFFF, 1'b0, 1'b0, 1'b0});
      add_row(req_type'{OP_UNUSED, 16'h1234, 1'b0, 8'd255, 1'b1}, 1'b1,
              rsp_type'{16'h0034, 1'b0, 1'b0, 1'b1});
      add_row(req_type'{OP_SHL, 16'hFFFF, 1'b1, 8'd255, 1'b1}, 1'b1,
              rsp_type'{16'h0000, 1'b0, 1'b1, 1'b1});
      add_row(req_type'{OP_SHR, 16'hFFFF, 1'b0, 8'd255, 1'b0}, 1'b1,
              rsp_type'{16'h0000, 1'b0, 1'b1, 1'b0});
      add_row(req_type'{OP_SAR, 16'h8000, 1'b1, 8'd255, 1'b0}, 1'b1,
              rsp_type'{16'hFFFF, 1'b1, 1'b1, 1'b0});
      add_row(req_type'{OP_SAR, 16'hFF7F, 1'b0, 8'd255, 1'b1}, 1'b1,
              rsp_type'{16'h0000, 1'b0, 1'b1, 1'b1});
      add_row(req_type'{OP_ROL, 16'hFFFF, 1'b1, 8'd255, 1'b0}, 1'b1,
              rsp_type'{16'hFFFF, 1'b1, 1'b1, 1'b0});
      add_row(req_type'{OP_ROR, 16'h0000, 1'b0, 8'd255, 1'b1}, 1'b1,
              rsp_type'{16'h0000, 1'b0, 1'b1, 1'b1});
      add_row(req_type'{OP_RCL, 16'h0000, 1'b1, 8'd1, 1'b1}, 1'b1,
              rsp_type'{16'h0001, 1'b1, 1'b1, 1'b0});
      add_row(req_type'{OP_RCR, 16'h0001, 1'b0, 8'd1, 1'b0}, 1'b1,
              rsp_type'{16'h0000, 1'b1, 1'b1, 1'b1});
      add_row(req_type'{OP_RCL, 16'hA5C3, 1'b0, 8'd9, 1'b1}, 1'b0, '0);
      add_row(req_type'{OP_RCR, 16'h8001, 1'b1, 8'd17, 1'b0}, 1'b0, '0);
      add_row(req_type'{OP_RCL, 16'h1357, 1'b1, 8'd255, 1'b0}, 1'b0, '0);
      add_row(req_type'{OP_RCR, 16'h00F0, 1'b0, 8'd255, 1'b1}, 1'b0, '0);
      add_row(req_type'{OP_ROL, 16'h0081, 1'b0, 8'd8, 1'b0}, 1'b0, '0);
      add_row(req_type'{OP_ROR, 16'h8001, 1'b1, 8'd16, 1'b1}, 1'b0, '0);
      add_row(req_type'{OP_SHL, 16'h0080, 1'b0, 8'd1, 1'b0}, 1'b0, '0);
      add_row(req_type'{OP_SHR, 16'h0001, 1'b1, 8'd1, 1'b1}, 1'b0, '0);
      add_row(req_type'{OP_SAR, 16'hFF80, 1'b0, 8'd3, 1'b0}, 1'b0, '0);
      add_row(req_type'{OP_ROL, 16'h4C21, 1'b1, 8'd128, 1'b1}, 1'b0, '0);
      add_row(req_type'{OP_ROR, 16'h5A00, 1'b0, 8'd7, 1'b0}, 1'b0, '0);
      add_row(req_type'{OP_SHL, 16'h7FFF, 1'b1, 8'd15, 1'b0}, 1'b0, '0);
      add_row(req_type'{OP_SAR, 16'h0055, 1'b0, 8'd1, 1'b1}, 1'b0, '0);

      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].req, directed_rows[i].typed ?
                      directed_rows[i].result : predict_shift(directed_rows[i].req));
         idle_sender(pick_gap());
      end

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n == 300 || n == 900) begin
            hold_off_request = 1'b1;
            burst_left = 60;
         end else if (n % 200 == 100) begin
            burst_left = 40;
         end
         item = random_request();
         send_request(item, predict_shift(item));
         if (burst_left > 0) begin
            burst_left--;
         end else if (n != RANDOM_REQUESTS - 1) begin
            idle_sender(pick_gap());
         end
      end
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d requests over all seven operations, the unused code, both widths",
               requests_sent);
      $display("and counts 0 to 255; checked %0d responses across %0d receiver hold-offs.",
               responses_checked, hold_off_count);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      int run;
      int stall;
      rsp_ready = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_count++;
         end else begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
            rsp_ready <= 1'b1;
            repeat (run) @(posedge clock);
            stall = pick_gap();
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_type wanted;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response shifted=%h last=%b valid=%b carry=%b",
                     $time, rsp_data.shifted, rsp_data.last_out_bit,
                     rsp_data.last_bit_valid, rsp_data.carry_out);
            mismatch_count++;
         end else begin
            wanted = pending_results.pop_front();
            responses_checked++;
            if (rsp_data !== wanted) begin
               $display("%0t: expected shifted=%h last=%b valid=%b carry=%b, got %h %b %b %b",
                        $time, wanted.shifted, wanted.last_out_bit, wanted.last_bit_valid,
                        wanted.carry_out, rsp_data.shifted, rsp_data.last_out_bit,
                        rsp_data.last_bit_valid, rsp_data.carry_out);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      #2000000;
      $display("Timeout with %0d responses outstanding.", pending_results.size());
      $display("Mismatches found");
      $finish;
   end

endmodule
